// ===== src/bleadc_pkg.sv =====
// ----------------------------------------------------------------------------
// BLE advertising device classifier - shared definitions
// Request and response payloads, table entry layout, AD type codes and the
// segment update passed from the byte parser to the hit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bleadc_pkg;

   localparam int unsigned MAX_DEVICES_DEF   = 32;
   localparam int unsigned MAX_ADV_BYTES_DEF = 62;

   localparam int unsigned ADDR_W  = 48;
   localparam int unsigned ENTRY_W = 5;

   // request opcodes
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_HIT   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // AD segment types
   localparam logic [7:0] AD_KIND_FLAGS   = 8'h01;
   localparam logic [7:0] AD_UUID16_PART  = 8'h02;
   localparam logic [7:0] AD_UUID16_FULL  = 8'h03;
   localparam logic [7:0] AD_UUID16_SOLIC = 8'h14;

   localparam logic [15:0] HID_UUID = 16'h1812;

   // top two address bits of random addresses
   localparam logic [1:0] TOP_RESOLVABLE = 2'b01;
   localparam logic [1:0] TOP_NONRESOLV  = 2'b00;

   localparam logic [1:0] ATYPE_PUBLIC = 2'd0;

   localparam logic [1:0] CLASS_PUBLIC     = 2'd0;
   localparam logic [1:0] CLASS_STATIC     = 2'd1;
   localparam logic [1:0] CLASS_RESOLVABLE = 2'd2;
   localparam logic [1:0] CLASS_NONRESOLV  = 2'd3;

   localparam logic [1:0] RISK_LOW    = 2'd0;
   localparam logic [1:0] RISK_MEDIUM = 2'd1;
   localparam logic [1:0] RISK_HIGH   = 2'd2;

   localparam logic [2:0] EVT_LAST_CONNECTABLE = 3'd1;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [47:0]       device_address;
      logic signed [7:0] rssi;
      logic [1:0]        address_type;
      logic [2:0]        event_type;
      logic [7:0]        adv_byte;
      logic              last_item;
   } bleadc_req_type;

   typedef struct packed {
      logic [4:0]        entry_index;
      logic              new_entry;
      logic              dropped;
      logic [1:0]        address_class;
      logic              connectable;
      logic              limited_discoverable;
      logic              general_discoverable;
      logic              classic_supported;
      logic              hid_service;
      logic [1:0]        risk_class;
      logic signed [7:0] hit_rssi;
   } bleadc_rsp_type;

   typedef struct packed {
      logic conn;
      logic limited;
      logic general;
      logic classic;
      logic hid;
   } bleadc_flags_type;

   typedef struct packed {
      bleadc_flags_type   flags;
      logic [ADDR_W-1:0]  address;
   } bleadc_entry_type;

   // update from a segment that just completed
   typedef struct packed {
      logic done;
      logic flags_valid;
      logic limited;
      logic general;
      logic no_classic;
      logic hid;
   } bleadc_seg_type;

endpackage

`default_nettype wire

// ===== src/ble_adv_device_classifier_top.sv =====
// ----------------------------------------------------------------------------
// BLE advertising device classifier
// Looks up each scan hit's device in a table, parses its AD segments and
// reports address class and risk class at the end of the hit.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  bleadc_req_type
//  rsp_      out        rsp_valid / rsp_stall  bleadc_rsp_type
//
//  A byte inside an open hit passes through S_BYTE, and S_FINISH if it ends
//  the hit. The first item of a hit searches the table through the RAM read
//  port and one address comparator, reading and comparing stored entries in
//  turn, then adds a new entry and applies the header. Reset is synchronous
//  and empties the table. The result sits in an output register; a stalled
//  result holds the sequencer only when the next result is ready to load.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_adv_device_classifier_top #(
   parameter int unsigned MAX_DEVICES   = bleadc_pkg::MAX_DEVICES_DEF,
   parameter int unsigned MAX_ADV_BYTES = bleadc_pkg::MAX_ADV_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bleadc_pkg::bleadc_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bleadc_pkg::bleadc_rsp_type rsp_data
);
   import bleadc_pkg::*;

   localparam int unsigned SLOT_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int unsigned CNT_W  = $clog2(MAX_DEVICES + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SRD    = 3'd1;
   localparam logic [2:0] S_SCMP   = 3'd2;
   localparam logic [2:0] S_ADD    = 3'd3;
   localparam logic [2:0] S_APPLY  = 3'd4;
   localparam logic [2:0] S_BYTE   = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic               hit_active_ff, hit_active_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic signed [7:0]  rssi_ff, rssi_in;
   logic [1:0]         class_ff, class_in;
   logic               conn_evt_ff, conn_evt_in;
   logic               dropped_ff, dropped_in;
   logic               new_ff, new_in;
   bleadc_flags_type   flags_ff, flags_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               has_byte_ff, has_byte_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bleadc_rsp_type     rsp_ff, rsp_in;

   logic               req_acc;
   logic               start_hit;
   logic               step;
   bleadc_seg_type     seg_upd;
   bleadc_flags_type   flags_upd;
   bleadc_entry_type   rd_entry;
   bleadc_entry_type   wr_entry;
   logic               wr_en;
   bleadc_rsp_type     result;

   function automatic logic [1:0] addr_class(input logic [1:0] atype,
                                             input logic [1:0] top);
      logic [1:0] cls;
      if (atype == ATYPE_PUBLIC) begin
         cls = CLASS_PUBLIC;
      end else if (top == TOP_RESOLVABLE) begin
         cls = CLASS_RESOLVABLE;
      end else if (top == TOP_NONRESOLV) begin
         cls = CLASS_NONRESOLV;
      end else begin
         cls = CLASS_STATIC;
      end
      return cls;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign start_hit = req_acc && ((req_data.opcode == OP_HIT) ||
                                  ((req_data.opcode == OP_BYTE) && !hit_active_ff));
   assign step      = (state_ff == S_BYTE) && !dropped_ff;

   bleadc_parse #(
      .MAX_ADV_BYTES(MAX_ADV_BYTES)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .start   (start_hit),
      .step    (step),
      .adv_byte(byte_ff),
      .seg_upd (seg_upd)
   );

   // apply a completed segment to the working flags
   always_comb begin
      flags_upd = flags_ff;
      if (seg_upd.done) begin
         if (seg_upd.flags_valid) begin
            flags_upd.limited = seg_upd.limited;
            flags_upd.general = seg_upd.general;
            flags_upd.classic = !seg_upd.no_classic;
         end
         if (seg_upd.hid) begin
            flags_upd.hid = 1'b1;
         end
      end
   end

   always_comb begin
      result = '0;
      result.hit_rssi = rssi_ff;
      if (dropped_ff) begin
         result.dropped = 1'b1;
      end else begin
         result.entry_index          = ENTRY_W'(slot_ff);
         result.new_entry            = new_ff;
         result.address_class        = class_ff;
         result.connectable          = flags_ff.conn;
         result.limited_discoverable = flags_ff.limited;
         result.general_discoverable = flags_ff.general;
         result.classic_supported    = flags_ff.classic;
         result.hid_service          = flags_ff.hid;
         if (flags_ff.conn && (flags_ff.limited || flags_ff.hid)) begin
            result.risk_class = RISK_HIGH;
         end else if (flags_ff.conn || class_ff == CLASS_PUBLIC ||
                      class_ff == CLASS_STATIC) begin
            result.risk_class = RISK_MEDIUM;
         end else begin
            result.risk_class = RISK_LOW;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      hit_active_in = hit_active_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      addr_in       = addr_ff;
      rssi_in       = rssi_ff;
      class_in      = class_ff;
      conn_evt_in   = conn_evt_ff;
      dropped_in    = dropped_ff;
      new_in        = new_ff;
      flags_in      = flags_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      has_byte_in   = has_byte_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               byte_in = req_data.adv_byte;
               last_in = req_data.last_item;
               if (req_data.opcode == OP_CLEAR) begin
                  count_in      = '0;
                  hit_active_in = 1'b0;
               end else if (start_hit) begin
                  hit_active_in = 1'b1;
                  addr_in       = req_data.device_address;
                  rssi_in       = req_data.rssi;
                  class_in      = addr_class(req_data.address_type,
                                             req_data.device_address[47:46]);
                  conn_evt_in   = (req_data.event_type <= EVT_LAST_CONNECTABLE);
                  dropped_in    = 1'b0;
                  new_in        = 1'b0;
                  idx_in        = '0;
                  has_byte_in   = (req_data.opcode == OP_BYTE);
                  state_in      = (count_ff == '0) ? S_ADD : S_SRD;
               end else if (req_data.opcode == OP_BYTE) begin
                  state_in = S_BYTE;
               end
            end
         end
         S_SRD: begin
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (rd_entry.address == addr_ff) begin
               slot_in  = idx_ff;
               flags_in = rd_entry.flags;
               state_in = S_APPLY;
            end else if ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff) begin
               state_in = S_ADD;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = S_SRD;
            end
         end
         S_ADD: begin
            if (count_ff == CNT_W'(MAX_DEVICES)) begin
               dropped_in = 1'b1;
            end else begin
               slot_in  = SLOT_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
               flags_in = '0;
               new_in   = 1'b1;
            end
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (!dropped_ff) begin
               flags_in.conn = flags_ff.conn || conn_evt_ff;
               wr_en         = 1'b1;
            end
            state_in = has_byte_ff ? S_BYTE : S_FINISH;
         end
         S_BYTE: begin
            if (!dropped_ff) begin
               flags_in = flags_upd;
               wr_en    = 1'b1;
            end
            state_in = last_ff ? S_FINISH : S_IDLE;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in        = result;
               rsp_valid_in  = 1'b1;
               hit_active_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign wr_entry.flags   = flags_in;
   assign wr_entry.address = addr_ff;

   bleadc_table #(
      .DEPTH(MAX_DEVICES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot_in),
      .wr_data(wr_entry),
      .rd_addr(idx_ff),
      .rd_data(rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hit_active_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hit_active_ff <= hit_active_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      slot_ff     <= slot_in;
      addr_ff     <= addr_in;
      rssi_ff     <= rssi_in;
      class_ff    <= class_in;
      conn_evt_ff <= conn_evt_in;
      dropped_ff  <= dropped_in;
      new_ff      <= new_in;
      flags_ff    <= flags_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      has_byte_ff <= has_byte_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== src/bleadc_table.sv =====
// ----------------------------------------------------------------------------
// Device table RAM
// One write port and one read port with registered read data; each word
// holds a device address and its flag bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bleadc_table #(
   parameter  int unsigned DEPTH = bleadc_pkg::MAX_DEVICES_DEF,
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  bleadc_pkg::bleadc_entry_type wr_data,
   input  logic [AW-1:0]               rd_addr,
   output bleadc_pkg::bleadc_entry_type rd_data
);
   import bleadc_pkg::*;

   bleadc_entry_type entry_ram [DEPTH];
   bleadc_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ram[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_ram[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/bleadc_parse.sv =====
// ----------------------------------------------------------------------------
// AD segment parser
// Walks length-type-value segments one byte per step and reports the flags
// and HID UUID found in each segment when the segment completes.
// ----------------------------------------------------------------------------
`default_nettype none

module bleadc_parse #(
   parameter int unsigned MAX_ADV_BYTES = bleadc_pkg::MAX_ADV_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      step,
   input  logic [7:0]                adv_byte,
   output bleadc_pkg::bleadc_seg_type seg_upd
);
   import bleadc_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_ADV_BYTES + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       rem_ff, rem_in;
   logic [7:0]       kind_ff, kind_in;
   logic             expect_ff, expect_in;
   logic             stopped_ff, stopped_in;
   logic             pend_fv_ff, pend_fv_in;
   logic [2:0]       pend_bits_ff, pend_bits_in;
   logic             pend_hid_ff, pend_hid_in;
   logic             uuid_v_ff, uuid_v_in;
   logic [7:0]       uuid_lo_ff, uuid_lo_in;

   always_comb begin
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      kind_in      = kind_ff;
      expect_in    = expect_ff;
      stopped_in   = stopped_ff;
      pend_fv_in   = pend_fv_ff;
      pend_bits_in = pend_bits_ff;
      pend_hid_in  = pend_hid_ff;
      uuid_v_in    = uuid_v_ff;
      uuid_lo_in   = uuid_lo_ff;
      seg_upd      = '0;
      if (start) begin
         pos_in       = '0;
         rem_in       = '0;
         kind_in      = '0;
         expect_in    = 1'b0;
         stopped_in   = 1'b0;
         pend_fv_in   = 1'b0;
         pend_bits_in = '0;
         pend_hid_in  = 1'b0;
         uuid_v_in    = 1'b0;
         uuid_lo_in   = '0;
      end else if (step && !stopped_ff && (pos_ff < POS_W'(MAX_ADV_BYTES))) begin
         pos_in = pos_ff + POS_W'(1);
         if (rem_ff == 8'd0) begin
            // length byte; zero ends parsing for this hit
            if (adv_byte == 8'd0) begin
               stopped_in = 1'b1;
            end else begin
               rem_in    = adv_byte;
               expect_in = 1'b1;
            end
         end else begin
            if (expect_ff) begin
               kind_in      = adv_byte;
               expect_in    = 1'b0;
               pend_fv_in   = 1'b0;
               pend_bits_in = '0;
               pend_hid_in  = 1'b0;
               uuid_v_in    = 1'b0;
               uuid_lo_in   = '0;
            end else if (kind_ff == AD_KIND_FLAGS) begin
               // only the first flags value byte counts
               if (!pend_fv_ff) begin
                  pend_fv_in   = 1'b1;
                  pend_bits_in = adv_byte[2:0];
                  pend_hid_in  = 1'b0;
               end
            end else if (kind_ff == AD_UUID16_PART || kind_ff == AD_UUID16_FULL ||
                         kind_ff == AD_UUID16_SOLIC) begin
               if (uuid_v_ff) begin
                  if ({adv_byte, uuid_lo_ff} == HID_UUID) begin
                     pend_hid_in = 1'b1;
                  end
                  uuid_v_in  = 1'b0;
                  uuid_lo_in = '0;
               end else begin
                  uuid_v_in  = 1'b1;
                  uuid_lo_in = adv_byte;
               end
            end
            rem_in = rem_ff - 8'd1;
            if (rem_ff == 8'd1) begin
               seg_upd.done        = 1'b1;
               seg_upd.flags_valid = pend_fv_in;
               seg_upd.limited     = pend_bits_in[0];
               seg_upd.general     = pend_bits_in[1];
               seg_upd.no_classic  = pend_bits_in[2];
               seg_upd.hid         = pend_hid_in;
               pend_fv_in   = 1'b0;
               pend_bits_in = '0;
               pend_hid_in  = 1'b0;
               uuid_v_in    = 1'b0;
               uuid_lo_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rem_ff       <= '0;
         kind_ff      <= '0;
         expect_ff    <= 1'b0;
         stopped_ff   <= 1'b0;
         pend_fv_ff   <= 1'b0;
         pend_bits_ff <= '0;
         pend_hid_ff  <= 1'b0;
         uuid_v_ff    <= 1'b0;
         uuid_lo_ff   <= '0;
      end else begin
         pos_ff       <= pos_in;
         rem_ff       <= rem_in;
         kind_ff      <= kind_in;
         expect_ff    <= expect_in;
         stopped_ff   <= stopped_in;
         pend_fv_ff   <= pend_fv_in;
         pend_bits_ff <= pend_bits_in;
         pend_hid_ff  <= pend_hid_in;
         uuid_v_ff    <= uuid_v_in;
         uuid_lo_ff   <= uuid_lo_in;
      end
   end

endmodule

`default_nettype wire
